// File: sv/mcvs_pkg.sv
package mcvs_pkg;

	localparam int CHANNELS = 16;
	localparam int CHN_W    = 4;
	localparam int KEY_W    = 7;
	localparam int VEL_W    = 7;
	localparam int TICK_W   = 32;
	localparam int NOTE_W   = 8;
	localparam int DEST_W   = 4;

	localparam logic [7:0]        KIND_MASK = 8'hF0;
	localparam logic [7:0]        NOTE_ON   = 8'h90;
	localparam logic [7:0]        NOTE_OFF  = 8'h80;
	localparam logic [NOTE_W-1:0] SLOT_FREE = 8'hFF;

	localparam int QDEPTH = 2;
	localparam int QAW    = $clog2(QDEPTH);

	typedef struct packed {
		logic [7:0]        status;
		logic [KEY_W-1:0]  key;
		logic [VEL_W-1:0]  velocity;
		logic [TICK_W-1:0] event_tick;
	} midi_item_t;

	typedef struct packed {
		logic [DEST_W-1:0] dest_track;
		logic              opened_track;
		logic              unmatched_off;
		logic              overflow;
	} split_result_t;

	typedef enum logic [1:0] {
		OP_OTHER,
		OP_ON,
		OP_OFF
	} op_t;

	typedef struct packed {
		op_t               op;
		logic [CHN_W-1:0]  chn;
		logic [KEY_W-1:0]  key;
		logic [TICK_W-1:0] tick;
	} queue_entry_t;

	typedef struct packed {
		logic [NOTE_W-1:0] note;
		logic [TICK_W-1:0] tick;
	} slot_t;

	typedef enum logic [1:0] {
		BS_CLEAR,
		BS_IDLE,
		BS_SCAN,
		BS_WRITE
	} back_state_t;

	typedef struct packed {
		logic clearing;
	} back_stat_t;

endpackage

// File: sv/mcvs_front.sv
module mcvs_front import mcvs_pkg::*; (
	input  logic         start,
	input  midi_item_t   item,
	input  logic         q_full,
	input  back_stat_t   stat,
	output logic         busy,
	output logic         push,
	output queue_entry_t entry
);

	logic [7:0] kind;

	assign kind = item.status & KIND_MASK;
	assign busy = q_full | stat.clearing;
	assign push = start & ~busy;

	always_comb begin
		entry.chn  = item.status[CHN_W-1:0];
		entry.key  = item.key;
		entry.tick = item.event_tick;
		// note-on with zero velocity counts as note-off
		if (kind == NOTE_ON && item.velocity != '0) begin
			entry.op = OP_ON;
		end else if (kind == NOTE_OFF || kind == NOTE_ON) begin
			entry.op = OP_OFF;
		end else begin
			entry.op = OP_OTHER;
		end
	end

endmodule

// File: sv/mcvs_queue.sv
module mcvs_queue import mcvs_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push,
	input  queue_entry_t entry_in,
	input  logic         pop,
	output logic         valid,
	output logic         full,
	output queue_entry_t entry_out
);

	queue_entry_t     entry_q [QDEPTH];
	logic [QAW-1:0]   wp_q;
	logic [QAW-1:0]   rp_q;
	logic [QAW:0]     cnt_q;

	assign valid     = (cnt_q != '0);
	assign full      = (cnt_q == (QAW+1)'(QDEPTH));
	assign entry_out = entry_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wp_q] <= entry_in;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == QAW'(QDEPTH-1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == QAW'(QDEPTH-1)) ? '0 : rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// File: sv/mcvs_back.sv
module mcvs_back import mcvs_pkg::*; #(
	parameter int MAX_TRACKS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          q_valid,
	input  queue_entry_t  q_entry,
	output logic          pop,
	output back_stat_t    stat,
	output logic          done,
	output split_result_t result
);

	localparam int TW    = (MAX_TRACKS > 1) ? $clog2(MAX_TRACKS) : 1;
	localparam int CNW   = $clog2(MAX_TRACKS + 1);
	localparam int AW    = TW + CHN_W;
	localparam int DEPTH = (2 ** TW) * CHANNELS;
	localparam logic [AW-1:0] CLR_LAST = AW'(MAX_TRACKS * CHANNELS - 1);

	back_state_t state_q, state_d;

	queue_entry_t      cur_q;
	logic [CNW-1:0]    iss_q;
	logic              rd_v_s1;
	logic [TW-1:0]     rd_t_s1;
	slot_t             rd_q;
	logic              found_q;
	logic [TW-1:0]     pick_q;
	logic [TICK_W-1:0] pick_tick_q;
	logic              hit_q;
	logic [TW-1:0]     hit_t_q;
	logic [CNW-1:0]    open_q;
	logic [AW-1:0]     clr_q;
	logic              done_q;
	split_result_t     res_q;

	slot_t mem [DEPTH];

	logic          issue;
	logic          on_hit;
	logic          take;
	logic          scan_end;
	logic          mem_we;
	logic [AW-1:0] mem_wa;
	slot_t         mem_wd;
	logic          open_inc;
	logic [TW-1:0] dest_t;
	logic [TW+DEST_W-1:0] dest_ext;
	split_result_t res_d;

	assign stat.clearing = (state_q == BS_CLEAR);
	assign done          = done_q;
	assign result        = res_q;

	assign issue    = (state_q == BS_SCAN) && (iss_q < open_q);
	assign on_hit   = rd_v_s1 && (cur_q.op == OP_ON) && (rd_q.note == SLOT_FREE);
	// a later match wins while the current pick started before this off
	assign take     = rd_v_s1 && (cur_q.op == OP_OFF) && (rd_q.note == {1'b0, cur_q.key})
		&& (!found_q || (pick_tick_q < cur_q.tick));
	assign scan_end = on_hit || (rd_v_s1 && (iss_q == open_q));
	assign dest_ext = {{DEST_W{1'b0}}, dest_t};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= BS_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		mem_we   = 1'b0;
		mem_wa   = {hit_t_q, cur_q.chn};
		mem_wd   = '{note: {1'b0, cur_q.key}, tick: cur_q.tick};
		open_inc = 1'b0;
		dest_t   = '0;
		res_d    = '0;
		case (state_q)
			BS_CLEAR: begin
				mem_we = 1'b1;
				mem_wa = clr_q;
				mem_wd = '{note: SLOT_FREE, tick: '0};
				if (clr_q == CLR_LAST) begin
					state_d = BS_IDLE;
				end
			end
			BS_IDLE: begin
				if (q_valid) begin
					pop     = 1'b1;
					state_d = (q_entry.op == OP_OTHER) ? BS_WRITE : BS_SCAN;
				end
			end
			BS_SCAN: begin
				if (scan_end) begin
					state_d = BS_WRITE;
				end
			end
			BS_WRITE: begin
				state_d = BS_IDLE;
				case (cur_q.op)
					OP_ON: begin
						if (hit_q) begin
							mem_we = 1'b1;
							dest_t = hit_t_q;
						end else if (open_q < CNW'(MAX_TRACKS)) begin
							mem_we             = 1'b1;
							dest_t             = open_q[TW-1:0];
							mem_wa             = {open_q[TW-1:0], cur_q.chn};
							open_inc           = 1'b1;
							res_d.opened_track = 1'b1;
						end else begin
							res_d.overflow = 1'b1;
						end
					end
					OP_OFF: begin
						if (found_q) begin
							mem_we = 1'b1;
							dest_t = pick_q;
							mem_wa = {pick_q, cur_q.chn};
							mem_wd = '{note: SLOT_FREE, tick: pick_tick_q};
						end else begin
							res_d.unmatched_off = 1'b1;
						end
					end
					default: begin
						dest_t = '0;
					end
				endcase
				res_d.dest_track = dest_ext[DEST_W-1:0];
			end
			default: begin
				state_d = BS_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (issue) begin
			rd_q <= mem[{iss_q[TW-1:0], cur_q.chn}];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_entry;
		end
		rd_t_s1 <= iss_q[TW-1:0];
		if (take) begin
			pick_q      <= rd_t_s1;
			pick_tick_q <= rd_q.tick;
		end
		if (state_q == BS_SCAN && scan_end) begin
			hit_t_q <= rd_t_s1;
		end
		res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q   <= '0;
			rd_v_s1 <= 1'b0;
			found_q <= 1'b0;
			hit_q   <= 1'b0;
			open_q  <= CNW'(1);
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q  <= (state_q == BS_WRITE);
			rd_v_s1 <= issue;
			if (state_q == BS_CLEAR) begin
				clr_q <= clr_q + 1'b1;
			end
			if (pop) begin
				iss_q   <= '0;
				found_q <= 1'b0;
				hit_q   <= 1'b0;
			end else begin
				if (issue) begin
					iss_q <= iss_q + 1'b1;
				end
				if (take) begin
					found_q <= 1'b1;
				end
				if (state_q == BS_SCAN && scan_end) begin
					hit_q <= on_hit;
				end
			end
			if (open_inc) begin
				open_q <= open_q + 1'b1;
			end
		end
	end

	a_no_result_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		stat.clearing |-> !done_q)
		else $error("result strobe during clearing pass");

	a_open_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(open_q >= CNW'(1)) && (open_q <= CNW'(MAX_TRACKS)))
		else $error("open track count out of range");

	a_one_flag: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> ($countones({res_q.opened_track, res_q.unmatched_off,
			res_q.overflow}) <= 1))
		else $error("more than one flag on a result");

	a_open_only_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != BS_WRITE) |=> $stable(open_q))
		else $error("open track count moved outside write step");

	a_overflow_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		(done_q && res_q.overflow) |-> (open_q == CNW'(MAX_TRACKS)))
		else $error("overflow flagged with tracks still available");

endmodule

// File: sv/midi_chord_voice_splitter_unit.sv
// midi chord voice splitter: assigns each midi event of one source track to an
// output track so that overlapping notes of a channel never share a track.
// input: an event transfer happens on a clock edge with start high and busy low;
// item carries status, key, velocity and event_tick.
// output: done is high for exactly one cycle with result valid in that cycle;
// the receiver cannot hold results off.
// a two-entry queue sits between the classifying front and the track scanner,
// so events are taken while the scanner works on an earlier one.
// the scanner reads one track slot per cycle from a single-port-read slot ram:
// a note-off scans every open track, a note-on stops at the first free slot
// (it scans all open tracks when it opens a track or overflows), and any other
// event skips the scan; results come out in event order, after any wait in the queue.
// after reset the slot ram is swept free, with busy high; one track is open after that.
module midi_chord_voice_splitter_unit import mcvs_pkg::*; #(
	parameter int MAX_TRACKS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  midi_item_t    item,
	output logic          busy,
	output logic          done,
	output split_result_t result
);

	logic         push;
	logic         pop;
	logic         q_valid;
	logic         q_full;
	queue_entry_t entry_in;
	queue_entry_t entry_out;
	back_stat_t   stat;

	mcvs_front u_front (
		.start  (start),
		.item   (item),
		.q_full (q_full),
		.stat   (stat),
		.busy   (busy),
		.push   (push),
		.entry  (entry_in)
	);

	mcvs_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.entry_in  (entry_in),
		.pop       (pop),
		.valid     (q_valid),
		.full      (q_full),
		.entry_out (entry_out)
	);

	mcvs_back #(
		.MAX_TRACKS (MAX_TRACKS)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_valid (q_valid),
		.q_entry (entry_out),
		.pop     (pop),
		.stat    (stat),
		.done    (done),
		.result  (result)
	);

endmodule

// File: tb/split_voice_checker.sv
module split_voice_checker import mcvs_pkg::*; #(
	parameter int MAX_TRACKS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          busy,
	input  midi_item_t    item,
	input  logic          done,
	input  split_result_t result,
	output int            fails,
	output int            pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [NOTE_W-1:0] slot_key [MAX_TRACKS][CHANNELS];
	logic [TICK_W-1:0] slot_tick [MAX_TRACKS][CHANNELS];
	int                open_tracks;
	split_result_t     due_q[$];
	split_result_t     want;

	function automatic split_result_t place_event(midi_item_t ev);
		split_result_t    r;
		logic [7:0]       kind;
		logic [CHN_W-1:0] chn;
		int               pick;
		bit               found;
		r = '0;
		kind = ev.status & KIND_MASK;
		chn = ev.status[CHN_W-1:0];
		found = 1'b0;
		pick = 0;
		if (kind == NOTE_ON && ev.velocity != '0) begin
			for (int t = 0; t < open_tracks && !found; t++) begin
				if (slot_key[t][chn] == SLOT_FREE) begin
					slot_key[t][chn] = {1'b0, ev.key};
					slot_tick[t][chn] = ev.event_tick;
					r.dest_track = DEST_W'(t);
					found = 1'b1;
				end
			end
			if (!found) begin
				if (open_tracks < MAX_TRACKS) begin
					for (int c = 0; c < CHANNELS; c++) begin
						slot_key[open_tracks][c] = SLOT_FREE;
						slot_tick[open_tracks][c] = '0;
					end
					slot_key[open_tracks][chn] = {1'b0, ev.key};
					slot_tick[open_tracks][chn] = ev.event_tick;
					r.dest_track = DEST_W'(open_tracks);
					r.opened_track = 1'b1;
					open_tracks++;
				end else begin
					r.overflow = 1'b1;
				end
			end
		end else if (kind == NOTE_OFF || kind == NOTE_ON) begin
			// later match wins only while the current pick started before the off
			for (int t = 0; t < open_tracks; t++) begin
				if (slot_key[t][chn] == {1'b0, ev.key}) begin
					if (!found) begin
						pick = t;
						found = 1'b1;
					end else if (slot_tick[pick][chn] < ev.event_tick) begin
						pick = t;
					end
				end
			end
			if (found) begin
				slot_key[pick][chn] = SLOT_FREE;
				r.dest_track = DEST_W'(pick);
			end else begin
				r.unmatched_off = 1'b1;
			end
		end
		return r;
	endfunction

	task automatic check_field(input string name, input logic [DEST_W-1:0] exp_v,
			input logic [DEST_W-1:0] got_v);
		if (got_v !== exp_v) begin
			$error("%s: expected %0d, actual %0d", name, exp_v, got_v);
			fails++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int t = 0; t < MAX_TRACKS; t++) begin
				for (int c = 0; c < CHANNELS; c++) begin
					slot_key[t][c] = SLOT_FREE;
					slot_tick[t][c] = '0;
				end
			end
			open_tracks = 1;
			due_q.delete();
			fails = 0;
			pending = 0;
		end else begin
			if (done) begin
				if (due_q.size() == 0) begin
					$error("result with no event outstanding: %p", result);
					fails++;
				end else begin
					want = due_q.pop_front();
					check_field("dest_track", want.dest_track, result.dest_track);
					check_field("opened_track", DEST_W'(want.opened_track),
						DEST_W'(result.opened_track));
					check_field("unmatched_off", DEST_W'(want.unmatched_off),
						DEST_W'(result.unmatched_off));
					check_field("overflow", DEST_W'(want.overflow), DEST_W'(result.overflow));
				end
			end
			if (start && !busy)
				due_q = {due_q, place_event(item)};
			pending = due_q.size();
		end
	end

endmodule

// File: tb/tb_top.sv
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import mcvs_pkg::*;

	localparam int MAX_TRACKS   = 16;
	localparam int EVENT_COUNT  = 870;
	localparam int CYCLE_LIMIT  = 250000;
	localparam int TAIL_CYCLES  = 2 * (MAX_TRACKS + 4);

	typedef struct packed {
		logic [CHN_W-1:0] chn;
		logic [KEY_W-1:0] key;
	} sounding_t;

	logic          clk;
	logic          arst_n = 1'b0;
	logic          start = 1'b0;
	midi_item_t    item = '0;
	logic          busy;
	logic          done;
	split_result_t result;
	int            fails;
	int            pending;
	int            cycles = 0;
	int            sent = 0;
	bit            eager = 1'b0;
	logic [TICK_W-1:0] now_tick = '0;
	sounding_t     sounding_q[$];

	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	midi_chord_voice_splitter_unit #(.MAX_TRACKS(MAX_TRACKS)) DUT (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.item  (item),
		.busy  (busy),
		.done  (done),
		.result(result)
	);

	split_voice_checker #(.MAX_TRACKS(MAX_TRACKS)) u_checker (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.item   (item),
		.done   (done),
		.result (result),
		.fails  (fails),
		.pending(pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("status: fail");
			$finish;
		end
	end

	// holds start until the transfer, then idles for a drawn number of cycles
	task automatic send_event(input logic [7:0] st, input logic [KEY_W-1:0] k,
			input logic [VEL_W-1:0] v, input logic [TICK_W-1:0] tk);
		int gap;
		start <= 1'b1;
		item <= '{status: st, key: k, velocity: v, event_tick: tk};
		@(posedge clk);
		while (busy)
			@(posedge clk);
		sent++;
		gap = eager ? 0 : $urandom_range(0, 17);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// ends a random sounding note, by either form of note-off
	task automatic drop_note();
		int        idx;
		sounding_t n;
		idx = $urandom_range(0, sounding_q.size() - 1);
		n = sounding_q[idx];
		sounding_q.delete(idx);
		if ($urandom_range(0, 7) == 0)
			now_tick = $urandom;
		else
			now_tick += $urandom_range(0, 3);
		if ($urandom_range(0, 1))
			send_event(NOTE_OFF | {4'h0, n.chn}, n.key, VEL_W'($urandom_range(0, 127)),
				now_tick);
		else
			send_event(NOTE_ON | {4'h0, n.chn}, n.key, '0, now_tick);
	endtask

	initial begin
		int               mode;
		int               n;
		int               k;
		logic [CHN_W-1:0] chn;
		logic [KEY_W-1:0] key;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// directed: extremes, duplicate keys, both off forms, unmatched offs, other kinds
		send_event(NOTE_ON | 8'h00, 7'd0, 7'd1, 32'h0000_0000);
		send_event(NOTE_ON | 8'h00, 7'd127, 7'd127, 32'hFFFF_FFFF);
		send_event(NOTE_ON | 8'h00, 7'd127, 7'd64, 32'd10);
		send_event(NOTE_OFF | 8'h00, 7'd127, 7'd127, 32'd5);
		send_event(NOTE_ON | 8'h00, 7'd127, 7'd0, 32'd100);
		send_event(NOTE_ON | 8'h01, 7'd60, 7'd100, 32'd1);
		send_event(NOTE_ON | 8'h01, 7'd60, 7'd100, 32'd2);
		send_event(NOTE_OFF | 8'h01, 7'd60, 7'd0, 32'd3);
		send_event(NOTE_OFF | 8'h01, 7'd60, 7'd0, 32'd3);
		send_event(NOTE_OFF | 8'h0F, 7'd33, 7'd85, 32'd7);
		send_event(NOTE_ON | 8'h0F, 7'd33, 7'd0, 32'd8);
		send_event(NOTE_ON | 8'h0F, 7'd64, 7'd127, 32'h8000_0000);
		send_event(8'hA5, 7'd127, 7'd127, 32'h5555_5555);
		send_event(8'hB0, 7'd0, 7'd0, 32'hAAAA_AAAA);
		send_event(8'hCF, 7'd42, 7'd21, 32'd0);
		send_event(8'hD3, 7'd85, 7'd42, 32'hFFFF_FFFF);
		send_event(8'hE7, 7'd1, 7'd126, 32'd9);
		send_event(8'hF0, 7'd64, 7'd64, 32'd11);
		send_event(8'hFF, 7'd127, 7'd1, 32'd12);
		send_event(8'h00, 7'd0, 7'd127, 32'd13);
		send_event(8'h7F, 7'd127, 7'd0, 32'd14);
		send_event(NOTE_ON | 8'h0F, 7'd64, 7'd0, 32'h8000_0001);

		// random: chords stacked on a few channels, drains, and raw noise
		while (sent < EVENT_COUNT) begin
			eager = ($urandom_range(0, 3) == 0);
			mode = $urandom_range(0, 9);
			if (mode <= 5) begin
				chn = CHN_W'($urandom_range(0, 1) ? $urandom_range(0, 2)
					: $urandom_range(0, 15));
				n = ($urandom_range(0, 3) == 0) ? $urandom_range(10, 20) : $urandom_range(1, 6);
				key = KEY_W'($urandom_range(0, 127));
				for (int i = 0; i < n; i++) begin
					if ($urandom_range(0, 3) != 0)
						key = KEY_W'($urandom_range(0, 127));
					if ($urandom_range(0, 9) == 0)
						now_tick = $urandom;
					else
						now_tick += $urandom_range(0, 3);
					sounding_q = {sounding_q, sounding_t'{chn: chn, key: key}};
					send_event(NOTE_ON | {4'h0, chn}, key, VEL_W'($urandom_range(1, 127)),
						now_tick);
				end
				k = $urandom_range(n / 2, n);
				for (int i = 0; i < k && sounding_q.size() > 0; i++)
					drop_note();
			end else if (mode == 6) begin
				while (sounding_q.size() > 0)
					drop_note();
			end else begin
				n = $urandom_range(1, 6);
				for (int i = 0; i < n; i++)
					send_event(8'($urandom_range(0, 255)), KEY_W'($urandom_range(0, 127)),
						VEL_W'($urandom_range(0, 127)), $urandom);
			end
		end
		start <= 1'b0;

		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (fails == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
